// File: hdl/leg_foot_trajectory_macros.svh
// ----------------------------------------------------------------------------
// Leg foot trajectory assertion macros
// Shared assertion wrappers for the trajectory checker.
// ----------------------------------------------------------------------------
`ifndef LEG_FOOT_TRAJECTORY_MACROS_SVH
`define LEG_FOOT_TRAJECTORY_MACROS_SVH

// assert on every clock edge outside reset
`define LFT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assert on every clock edge, reset included
`define LFT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lft_pkg.sv
// ----------------------------------------------------------------------------
// Leg foot trajectory package
// Item types, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package lft_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PROG_W      = FRAC_BITS + 1;
  localparam int LEN_W       = 18;
  localparam int X_W         = 19;
  localparam int Z_W         = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;
  localparam int PIPE_LATENCY = 6;

  localparam logic [PROG_W-1:0] ONE  = PROG_W'(1) << FRAC_BITS;
  localparam logic [PROG_W-1:0] HALF = PROG_W'(1) << (FRAC_BITS - 1);

  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIFT_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_MODE   = 2'd2;

  typedef struct packed {
    logic [PROG_W-1:0] progress;
    logic              swing;
  } item_t;

  typedef struct packed {
    logic signed [X_W-1:0] foot_x;
    logic        [Z_W-1:0] foot_z;
  } result_t;

  typedef struct packed {
    logic valid;
    logic swing;
  } tag_t;

endpackage

// File: hdl/lft_warp.sv
// ----------------------------------------------------------------------------
// Leg foot trajectory progress warp
// Three-stage quintic smoothstep of the progress, or a plain delay in
// linear mode.
// ----------------------------------------------------------------------------
module lft_warp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mode,
  input  lft_pkg::tag_t             in_tag,
  input  logic [lft_pkg::PROG_W-1:0] in_p,
  output lft_pkg::tag_t             out_tag,
  output logic [lft_pkg::PROG_W-1:0] out_u
);
  import lft_pkg::*;

  localparam int POLY_W  = 22;
  localparam int POLYU_W = 20;
  localparam logic [POLY_W-1:0] POLY_BASE = POLY_W'(10) << FRAC_BITS;

  tag_t              b_tag, c_tag;
  logic [PROG_W-1:0] b_p, b_s2, c_p, c_s3;
  logic [POLYU_W-1:0] c_poly;

  logic [2*PROG_W-1:0]        sq;
  logic [2*PROG_W-1:0]        cube;
  logic [POLY_W-1:0]          poly;
  logic [PROG_W+POLYU_W-1:0]  quint;
  logic [PROG_W+POLYU_W-FRAC_BITS-1:0] u_full;
  logic [PROG_W-1:0]          u_smooth;

  assign sq   = (2*PROG_W)'(in_p) * (2*PROG_W)'(in_p);
  assign cube = (2*PROG_W)'(b_s2) * (2*PROG_W)'(b_p);
  assign poly = POLY_BASE - (POLY_W'(b_p) << 4) + POLY_W'(b_p)
              + (POLY_W'(b_s2) << 2) + (POLY_W'(b_s2) << 1);

  assign quint  = (PROG_W+POLYU_W)'(c_s3) * (PROG_W+POLYU_W)'(c_poly);
  assign u_full = quint[PROG_W+POLYU_W-1:FRAC_BITS];
  assign u_smooth = (u_full > (PROG_W+POLYU_W-FRAC_BITS)'(ONE)) ? ONE : u_full[PROG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag   <= '0;
      c_tag   <= '0;
      out_tag <= '0;
    end else begin
      b_tag   <= in_tag;
      c_tag   <= b_tag;
      out_tag <= c_tag;
    end
  end

  always_ff @(posedge clk) begin
    b_p    <= in_p;
    b_s2   <= sq[FRAC_BITS+PROG_W-1:FRAC_BITS];
    c_p    <= b_p;
    c_s3   <= cube[FRAC_BITS+PROG_W-1:FRAC_BITS];
    c_poly <= poly[POLY_W-1] ? '0 : poly[POLYU_W-1:0];
    out_u  <= mode ? u_smooth : c_p;
  end

endmodule

// File: hdl/leg_foot_trajectory.sv
// ----------------------------------------------------------------------------
// Leg foot trajectory
// Parabolic swing / linear stance foot path with optional quintic
// smoothstep of the gait progress.
// ----------------------------------------------------------------------------
// channel   ports                         handshake
// input     item (progress, swing)        start high, busy low
// result    result (foot_x, foot_z)       done strobe, one cycle
// config    cfg_index, cfg_data           cfg_we high
//
// Six-stage pipeline: stage a, the warp stages b, c and d, stage e and the output register.
// One item is taken every cycle; busy is never raised.
// Every stage is registered and nothing waits, so the rate is one item a cycle.
// Synchronous reset empties the pipeline and clears the config registers and valid flags to zero.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module leg_foot_trajectory (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  lft_pkg::item_t                  item,
  output logic                            done,
  output lft_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [lft_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lft_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lft_pkg::*;

  localparam int D_W  = PROG_W + 1;
  localparam int MX_W = LEN_W + PROG_W;
  localparam int WP_W = 2 * PROG_W;
  localparam int ZP_W = LEN_W + PROG_W;

  logic [LEN_W-1:0] stride_length, lift_height;
  logic             smooth_mode;

  tag_t              a_tag, d_tag;
  logic [PROG_W-1:0] a_p, d_u;

  logic              e_valid, e_neg, e_zen;
  logic [MX_W-1:0]   e_mx;
  logic [WP_W-1:0]   e_wp;

  logic              accept;
  logic [D_W-1:0]    offset;
  logic              offset_neg;
  logic [PROG_W-1:0] offset_mag;
  logic [X_W-1:0]    x_mag;
  logic [PROG_W-1:0] w;
  logic [ZP_W-1:0]   zp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_length <= '0;
      lift_height   <= '0;
      smooth_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIDE_LENGTH: stride_length <= cfg_data[LEN_W-1:0];
        REG_LIFT_HEIGHT:   lift_height   <= cfg_data[LEN_W-1:0];
        REG_SMOOTH_MODE:   smooth_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate progress above one
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else begin
      a_tag <= '{valid: accept, swing: item.swing};
    end
  end

  always_ff @(posedge clk) begin
    a_p <= (item.progress > ONE) ? ONE : item.progress;
  end

  lft_warp u_warp (
    .clk     (clk),
    .rst     (rst),
    .mode    (smooth_mode),
    .in_tag  (a_tag),
    .in_p    (a_p),
    .out_tag (d_tag),
    .out_u   (d_u)
  );

  always_comb begin
    offset     = d_tag.swing ? (D_W'(d_u) - D_W'(HALF)) : (D_W'(HALF) - D_W'(d_u));
    offset_neg = offset[D_W-1];
    offset_mag = offset_neg ? PROG_W'(-offset) : offset[PROG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    e_neg <= offset_neg;
    e_zen <= d_tag.swing && (stride_length != '0);
    e_mx  <= MX_W'(stride_length) * MX_W'(offset_mag);
    e_wp  <= WP_W'(d_u) * WP_W'(ONE - d_u);
  end

  // truncate toward zero on the magnitude, then restore the sign
  always_comb begin
    x_mag = e_mx[MX_W-1:FRAC_BITS];
    w     = e_wp[FRAC_BITS-2+PROG_W-1:FRAC_BITS-2];
    zp    = ZP_W'(lift_height) * ZP_W'(w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.foot_x <= e_neg ? -x_mag : x_mag;
    result.foot_z <= e_zen ? zp[FRAC_BITS+Z_W-1:FRAC_BITS] : '0;
  end

endmodule

// File: hdl/lft_checker.sv
// ----------------------------------------------------------------------------
// Leg foot trajectory checker
// Port-level checks on latency, stance height and quiet after reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "leg_foot_trajectory_macros.svh"

module lft_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  lft_pkg::item_t   item,
  input  logic             done,
  input  lft_pkg::result_t result
);
  import lft_pkg::*;

  `LFT_ASSERT(a_item_gives_result, clk, rst, (start && !busy) |-> ##PIPE_LATENCY done, "item without result")
  `LFT_ASSERT(a_result_has_item, clk, rst, done |-> $past(start && !busy, PIPE_LATENCY), "result without item")
  `LFT_ASSERT(a_stance_on_ground, clk, rst, (done && !$past(item.swing, PIPE_LATENCY)) |-> (result.foot_z == '0), "stance foot lifted")
  `LFT_ASSERT_ALWAYS(a_quiet_in_reset, clk, $past(rst) |-> !done, "result straight after reset")

endmodule

bind leg_foot_trajectory lft_checker u_lft_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
